@@ design/rsenc_pkg.sv @@
// Shared types, constants and GF(256) helpers of the Reed-Solomon encoder.
package rsenc_pkg;

	localparam logic [8:0] FIELD_POLY = 9'h11D;
	localparam logic [4:0] ECC_RESET  = 5'd10;
	localparam int         ECC_LIMIT  = 30;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_data;
	} data_item_t;

	typedef struct packed {
		logic [7:0] ecc_byte;
		logic       last_ecc;
	} ecc_item_t;

	// multiply by alpha, reduce by the field polynomial
	function automatic logic [7:0] gf_xtime(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? FIELD_POLY[7:0] : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ x;
			x = gf_xtime(x);
		end
		return acc;
	endfunction

endpackage

@@ design/rsenc_gen.sv @@
// Generator polynomial builder: multiplies in one (x + alpha^d) factor per cycle.
module rsenc_gen #(
	parameter int CAP = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [$clog2(CAP+1)-1:0]     start_len,
	output logic [7:0]                   coef [CAP+1],
	output logic                         busy
);

	localparam int CNT_W = $clog2(CAP + 1);
	localparam int RESET_N = (int'(rsenc_pkg::ECC_RESET) > CAP) ? CAP
		: int'(rsenc_pkg::ECC_RESET);

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       root_q;
	logic [7:0]       coef_q [CAP+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= CNT_W'(RESET_N);
			root_q <= 8'h01;
			for (int j = 0; j <= CAP; j++) coef_q[j] <= (j == 0) ? 8'h01 : 8'h00;
		end else if (start) begin
			cnt_q  <= start_len;
			root_q <= 8'h01;
			for (int j = 0; j <= CAP; j++) coef_q[j] <= (j == 0) ? 8'h01 : 8'h00;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - CNT_W'(1);
			root_q <= rsenc_pkg::gf_xtime(root_q);
			// terms above the current degree are zero, so one formula covers all
			for (int j = 1; j <= CAP; j++)
				coef_q[j] <= coef_q[j] ^ rsenc_pkg::gf_mul(coef_q[j-1], root_q);
		end
	end

	assign coef = coef_q;
	assign busy = (cnt_q != '0);

endmodule

@@ design/qr_reed_solomon_ecc_encoder_top.sv @@
// Top level of the QR-code Reed-Solomon parity encoder over GF(256).
//
// Data channel (data_valid / data_stall / data_item) takes one data codeword
// per item; last_data marks the end of a block. Parity channel (ecc_valid /
// ecc_stall / ecc_item) returns the n parity codewords of each block, highest
// degree first, last_ecc on the final one. n is ecc_length, with 0 read as 1
// and values above min(MAX_ECC, 30) clamped.
// Throughput: one data item per cycle while data_stall is low, set by the
// remainder update in which all remainder bytes are refreshed by parallel GF
// multiplies. An item waits in the input register; the first parity item of
// a block is valid once its last data item has left the input register and
// the final remainder is loaded into the output buffer; the rest follow one
// per cycle while ecc_stall is low. Parity is drained from the output buffer,
// so the next block streams in meanwhile; a last item is held in the input
// register only while the previous block's parity has not yet been taken. A
// stalled parity item holds. After reset, and after every write of ecc_length,
// the generator is rebuilt, with data_stall high. A write clears the remainder.
module qr_reed_solomon_ecc_encoder_top #(
	parameter int MAX_ECC = 30
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    data_valid,
	output logic                    data_stall,
	input  rsenc_pkg::data_item_t   data_item,
	output logic                    ecc_valid,
	input  logic                    ecc_stall,
	output rsenc_pkg::ecc_item_t    ecc_item,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam int CAP   = (MAX_ECC < rsenc_pkg::ECC_LIMIT) ? MAX_ECC : rsenc_pkg::ECC_LIMIT;
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int RESET_N = (int'(rsenc_pkg::ECC_RESET) > CAP) ? CAP
		: int'(rsenc_pkg::ECC_RESET);

	logic             cfg_wr;
	logic [4:0]       len_d;
	logic [4:0]       eff_len;
	logic [CNT_W-1:0] n_d;
	logic [4:0]       len_q;
	logic [CNT_W-1:0] n_q;

	logic [7:0]       coef [CAP+1];
	logic             gen_busy;

	logic             in_take;
	logic             v_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic             s1_adv;
	logic             use_s1;
	logic             load;

	logic [7:0]       rem_q  [CAP];
	logic [7:0]       rem_d  [CAP];
	logic [7:0]       fb;

	logic [7:0]       obuf_q [CAP];
	logic [CNT_W-1:0] ocnt_q;
	logic             out_go;
	logic             out_free;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready && !paddr[2];
	assign len_d   = pwdata[4:0];
	assign prdata  = paddr[2] ? 32'h0 : {27'h0, len_q};

	always_comb begin
		if (len_d == 5'd0)
			eff_len = 5'd1;
		else if (len_d > 5'(CAP))
			eff_len = 5'(CAP);
		else
			eff_len = len_d;
	end
	assign n_d = CNT_W'(eff_len);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= rsenc_pkg::ECC_RESET;
			n_q   <= CNT_W'(RESET_N);
		end else if (cfg_wr) begin
			len_q <= len_d;
			n_q   <= n_d;
		end
	end

	rsenc_gen #(.CAP(CAP)) u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cfg_wr),
		.start_len (n_d),
		.coef      (coef),
		.busy      (gen_busy)
	);

	// handshake control
	assign out_go     = ecc_valid && !ecc_stall;
	assign out_free   = (ocnt_q == '0) || ((ocnt_q == CNT_W'(1)) && !ecc_stall);
	assign s1_adv     = !last_s1 || out_free;
	assign use_s1     = v_s1 && s1_adv;
	assign load       = use_s1 && last_s1;
	assign data_stall = gen_busy || (v_s1 && !s1_adv);
	assign in_take    = data_valid && !data_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_take || (v_s1 && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_s1 <= data_item.data_byte;
			last_s1 <= data_item.last_data;
		end
	end

	// division LFSR step; entries at and above n stay zero
	assign fb = data_s1 ^ rem_q[0];
	always_comb begin
		for (int i = 0; i < CAP; i++)
			rem_d[i] = ((i < CAP - 1) ? rem_q[(i + 1) % CAP] : 8'h00)
				^ rsenc_pkg::gf_mul(fb, coef[i+1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAP; i++) rem_q[i] <= 8'h00;
		end else if (cfg_wr || load) begin
			for (int i = 0; i < CAP; i++) rem_q[i] <= 8'h00;
		end else if (use_s1) begin
			rem_q <= rem_d;
		end
	end

	// parity output buffer: load the final remainder, shift out one byte per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
		end else if (load) begin
			ocnt_q <= n_q;
		end else if (out_go) begin
			ocnt_q <= ocnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obuf_q <= rem_d;
		end else if (out_go) begin
			for (int i = 0; i < CAP; i++)
				obuf_q[i] <= (i < CAP - 1) ? obuf_q[(i + 1) % CAP] : 8'h00;
		end
	end

	assign ecc_valid         = (ocnt_q != '0);
	assign ecc_item.ecc_byte = obuf_q[0];
	assign ecc_item.last_ecc = (ocnt_q == CNT_W'(1));

	// an ecc_length write always triggers a rebuild that holds off data items
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> data_stall)
		else $error("data channel open right after ecc_length write");

	// a finished block hands over exactly n parity items
	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (ocnt_q == $past(n_q)))
		else $error("parity count does not match ecc length");

	// no parity item follows the final one unless a new block was loaded
	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_go && ecc_item.last_ecc && !load) |=> !ecc_valid)
		else $error("parity item after last_ecc without new block");

endmodule
